// ----- hw/rtl/lcrf_pkg.sv -----
`default_nettype none

package lcrf_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int CNT_W        = 11;
    localparam int RANGE_W      = 16;
    localparam int ANGLE_W      = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ITER_W       = 5;
    localparam int CORDIC_W     = 32;
    localparam int ATAN_W       = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam int XY_W         = 18;
    localparam int MUL_W        = 36;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int RR_W         = 35;
    localparam int STEP_W       = 3;

    localparam int SXX_W = 44;
    localparam int SXY_W = 45;
    localparam int SX_W  = 28;
    localparam int SXR_W = 62;
    localparam int SR_W  = 45;

    localparam int RADIUS_W = 20;
    localparam int STATUS_W = 2;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    // every determinant stays below 2^192, so 256*N fits a signed 400 bit word
    localparam int BIG_W    = 400;
    localparam int SQ_ITER  = BIG_W / 2;
    localparam int SQ_W     = SQ_ITER + 3;
    localparam int SQ_CNT_W = 8;
    localparam int DIV_W    = SQ_ITER + 16;
    localparam int Q_W      = RADIUS_W + 1;
    localparam int UPC_W    = 5;
    localparam int UCODE_LAST = 26;

    localparam logic [STATUS_W-1:0] FIT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] FIT_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] FIT_SINGULAR = 2'd2;
    localparam logic [STATUS_W-1:0] FIT_NEG_RAD  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ACCUM,
        ST_START,
        ST_SOLVE,
        ST_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        SV_IDLE,
        SV_LOAD_A,
        SV_LOAD_B,
        SV_MUL,
        SV_CHECK,
        SV_SQRT,
        SV_DIV_INIT,
        SV_DIV,
        SV_DONE
    } sv_state_t;

    typedef enum logic [3:0] {
        SRC_XX, SRC_XY, SRC_X, SRC_YY, SRC_Y, SRC_XR, SRC_YR, SRC_R, SRC_N,
        SRC_C00, SRC_C01, SRC_C02, SRC_C11, SRC_C12, SRC_C22, SRC_D
    } src_t;

    typedef struct packed {
        src_t a;
        src_t b;
        logic neg;
        logic shl2;
        logic clr;
        logic wr;
        src_t dst;
    } ucode_t;

    typedef struct packed {
        logic [SXX_W-1:0] sum_xx;
        logic [SXY_W-1:0] sum_xy;
        logic [SX_W-1:0]  sum_x;
        logic [SXX_W-1:0] sum_yy;
        logic [SX_W-1:0]  sum_y;
        logic [SXR_W-1:0] sum_x_rsq;
        logic [SXR_W-1:0] sum_y_rsq;
        logic [SR_W-1:0]  sum_rsq;
        logic [CNT_W-1:0] count;
    } lcrf_sums_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [STATUS_W-1:0] status;
    } lcrf_fit_t;

    function automatic logic [ATAN_W-1:0] lcrf_atan(input logic [ITER_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic ucode_t uc(input src_t a, input src_t b, input logic neg,
                                  input logic shl2, input logic clr, input logic wr,
                                  input src_t dst);
        ucode_t u;
        u.a    = a;
        u.b    = b;
        u.neg  = neg;
        u.shl2 = shl2;
        u.clr  = clr;
        u.wr   = wr;
        u.dst  = dst;
        return u;
    endfunction

    // cofactors of the symmetric normal matrix, then D, Da, Db, Dc by expansion
    // along a column, then N = 4*Dc*D + Da^2 + Db^2 left in the accumulator
    function automatic ucode_t lcrf_ucode(input logic [UPC_W-1:0] pc);
        ucode_t u;
        case (pc)
            5'd0:    u = uc(SRC_YY,  SRC_N,   1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd1:    u = uc(SRC_Y,   SRC_Y,   1'b1, 1'b0, 1'b0, 1'b1, SRC_C00);
            5'd2:    u = uc(SRC_XY,  SRC_N,   1'b1, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd3:    u = uc(SRC_Y,   SRC_X,   1'b0, 1'b0, 1'b0, 1'b1, SRC_C01);
            5'd4:    u = uc(SRC_XY,  SRC_Y,   1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd5:    u = uc(SRC_YY,  SRC_X,   1'b1, 1'b0, 1'b0, 1'b1, SRC_C02);
            5'd6:    u = uc(SRC_XX,  SRC_N,   1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd7:    u = uc(SRC_X,   SRC_X,   1'b1, 1'b0, 1'b0, 1'b1, SRC_C11);
            5'd8:    u = uc(SRC_XY,  SRC_X,   1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd9:    u = uc(SRC_XX,  SRC_Y,   1'b1, 1'b0, 1'b0, 1'b1, SRC_C12);
            5'd10:   u = uc(SRC_XX,  SRC_YY,  1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd11:   u = uc(SRC_XY,  SRC_XY,  1'b1, 1'b0, 1'b0, 1'b1, SRC_C22);
            5'd12:   u = uc(SRC_XX,  SRC_C00, 1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd13:   u = uc(SRC_XY,  SRC_C01, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            5'd14:   u = uc(SRC_X,   SRC_C02, 1'b0, 1'b0, 1'b0, 1'b1, SRC_D);
            5'd15:   u = uc(SRC_XR,  SRC_C00, 1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd16:   u = uc(SRC_YR,  SRC_C01, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            5'd17:   u = uc(SRC_R,   SRC_C02, 1'b0, 1'b0, 1'b0, 1'b1, SRC_C00);
            5'd18:   u = uc(SRC_XR,  SRC_C01, 1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd19:   u = uc(SRC_YR,  SRC_C11, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            5'd20:   u = uc(SRC_R,   SRC_C12, 1'b0, 1'b0, 1'b0, 1'b1, SRC_C11);
            5'd21:   u = uc(SRC_XR,  SRC_C02, 1'b0, 1'b0, 1'b1, 1'b0, SRC_D);
            5'd22:   u = uc(SRC_YR,  SRC_C12, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            5'd23:   u = uc(SRC_R,   SRC_C22, 1'b0, 1'b0, 1'b0, 1'b1, SRC_C22);
            5'd24:   u = uc(SRC_C22, SRC_D,   1'b0, 1'b1, 1'b1, 1'b0, SRC_D);
            5'd25:   u = uc(SRC_C00, SRC_C00, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            5'd26:   u = uc(SRC_C11, SRC_C11, 1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
            default: u = uc(SRC_XX,  SRC_XX,  1'b0, 1'b0, 1'b0, 1'b0, SRC_D);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcrf_solver.sv -----
`default_nettype none

module lcrf_solver
    import lcrf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire lcrf_sums_t sums,
    output logic            done,
    output lcrf_fit_t       fit
);

    sv_state_t state_reg, state_next;

    logic [UPC_W-1:0]    pc_reg;
    logic [BIG_W-1:0]    a_reg, b_reg, acc_reg;
    logic [BIG_W-1:0]    c00_reg, c01_reg, c02_reg, c11_reg, c12_reg, c22_reg, d_reg;
    logic [SQ_W-1:0]     rem_reg;
    logic [SQ_ITER-1:0]  root_reg;
    logic [DIV_W-1:0]    num_reg, den_reg;
    logic [Q_W-1:0]      q_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [STATUS_W-1:0] status_reg;

    ucode_t           op;
    src_t             src_sel;
    logic [BIG_W-1:0] src_val, a_ld;
    logic             b_zero, last_pc, sq_last, div_last;
    logic [SQ_W-1:0]  rem_sh, trial;
    logic             sq_ge, div_ge;
    logic [Q_W-1:0]   q_fin;

    assign op      = lcrf_ucode(pc_reg);
    assign src_sel = (state_reg == SV_LOAD_B) ? op.b : op.a;
    assign b_zero  = (b_reg == '0);
    assign last_pc = (pc_reg == UPC_W'(UCODE_LAST));
    assign sq_last  = (cnt_reg == SQ_CNT_W'(SQ_ITER - 1));
    assign div_last = (cnt_reg == SQ_CNT_W'(Q_W - 1));

    always_comb
    begin
        case (src_sel)
            SRC_XX:  src_val = {{(BIG_W-SXX_W){sums.sum_xx[SXX_W-1]}}, sums.sum_xx};
            SRC_XY:  src_val = {{(BIG_W-SXY_W){sums.sum_xy[SXY_W-1]}}, sums.sum_xy};
            SRC_X:   src_val = {{(BIG_W-SX_W){sums.sum_x[SX_W-1]}}, sums.sum_x};
            SRC_YY:  src_val = {{(BIG_W-SXX_W){sums.sum_yy[SXX_W-1]}}, sums.sum_yy};
            SRC_Y:   src_val = {{(BIG_W-SX_W){sums.sum_y[SX_W-1]}}, sums.sum_y};
            SRC_XR:  src_val = {{(BIG_W-SXR_W){sums.sum_x_rsq[SXR_W-1]}}, sums.sum_x_rsq};
            SRC_YR:  src_val = {{(BIG_W-SXR_W){sums.sum_y_rsq[SXR_W-1]}}, sums.sum_y_rsq};
            SRC_R:   src_val = {{(BIG_W-SR_W){sums.sum_rsq[SR_W-1]}}, sums.sum_rsq};
            SRC_N:   src_val = {{(BIG_W-CNT_W){1'b0}}, sums.count};
            SRC_C00: src_val = c00_reg;
            SRC_C01: src_val = c01_reg;
            SRC_C02: src_val = c02_reg;
            SRC_C11: src_val = c11_reg;
            SRC_C12: src_val = c12_reg;
            SRC_C22: src_val = c22_reg;
            SRC_D:   src_val = d_reg;
            default: src_val = '0;
        endcase
    end

    assign a_ld = op.neg ? (~src_val + BIG_W'(1)) : src_val;

    // one result bit of the root per step, two radicand bits shifted in from a_reg
    assign rem_sh = {rem_reg[SQ_W-3:0], a_reg[BIG_W-1:BIG_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    assign div_ge = (num_reg >= den_reg);
    assign q_fin  = {q_reg[Q_W-2:0], div_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SV_IDLE:
            begin
                if (start)
                begin
                    state_next = SV_LOAD_A;
                end
            end
            SV_LOAD_A:   state_next = SV_LOAD_B;
            SV_LOAD_B:   state_next = SV_MUL;
            SV_MUL:
            begin
                if (b_zero)
                begin
                    state_next = last_pc ? SV_CHECK : SV_LOAD_A;
                end
            end
            SV_CHECK:
            begin
                if (d_reg == '0 || acc_reg[BIG_W-1])
                begin
                    state_next = SV_DONE;
                end
                else
                begin
                    state_next = SV_SQRT;
                end
            end
            SV_SQRT:
            begin
                if (sq_last)
                begin
                    state_next = SV_DIV_INIT;
                end
            end
            SV_DIV_INIT: state_next = SV_DIV;
            SV_DIV:
            begin
                if (div_last)
                begin
                    state_next = SV_DONE;
                end
            end
            SV_DONE:     state_next = SV_IDLE;
            default:     state_next = SV_IDLE;
        endcase
    end

    assign done       = (state_reg == SV_DONE);
    assign fit.radius = radius_reg;
    assign fit.status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                SV_IDLE:     pc_reg <= '0;
                SV_MUL:
                begin
                    if (b_zero && !last_pc)
                    begin
                        pc_reg <= pc_reg + UPC_W'(1);
                    end
                end
                SV_CHECK:    cnt_reg <= '0;
                SV_SQRT:     cnt_reg <= sq_last ? '0 : cnt_reg + SQ_CNT_W'(1);
                SV_DIV:      cnt_reg <= cnt_reg + SQ_CNT_W'(1);
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SV_LOAD_A:
            begin
                a_reg <= op.shl2 ? {a_ld[BIG_W-3:0], 2'b00} : a_ld;
                if (op.clr)
                begin
                    acc_reg <= '0;
                end
            end
            SV_LOAD_B:   b_reg <= src_val;
            SV_MUL:
            begin
                if (b_zero)
                begin
                    if (op.wr)
                    begin
                        case (op.dst)
                            SRC_C00: c00_reg <= acc_reg;
                            SRC_C01: c01_reg <= acc_reg;
                            SRC_C02: c02_reg <= acc_reg;
                            SRC_C11: c11_reg <= acc_reg;
                            SRC_C12: c12_reg <= acc_reg;
                            SRC_C22: c22_reg <= acc_reg;
                            SRC_D:   d_reg   <= acc_reg;
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
                    a_reg   <= {a_reg[BIG_W-2:0], 1'b0};
                    b_reg   <= {1'b0, b_reg[BIG_W-1:1]};
                end
            end
            SV_CHECK:
            begin
                radius_reg <= '0;
                if (d_reg == '0)
                begin
                    status_reg <= FIT_SINGULAR;
                end
                else
                begin
                    status_reg <= FIT_NEG_RAD;
                end
                a_reg    <= {acc_reg[BIG_W-9:0], 8'd0};
                b_reg    <= d_reg[BIG_W-1] ? (~d_reg + BIG_W'(1)) : d_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            SV_SQRT:
            begin
                a_reg    <= {a_reg[BIG_W-3:0], 2'b00};
                rem_reg  <= sq_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[SQ_ITER-2:0], sq_ge};
            end
            SV_DIV_INIT:
            begin
                // num = isqrt + |D|, den = 2|D| placed at quotient bit 20
                num_reg <= {{(DIV_W-SQ_ITER){1'b0}}, root_reg} + b_reg[DIV_W-1:0];
                den_reg <= {b_reg[DIV_W-Q_W-1:0], {Q_W{1'b0}}};
                q_reg   <= '0;
            end
            SV_DIV:
            begin
                if (div_ge)
                begin
                    num_reg <= num_reg - den_reg;
                end
                den_reg <= {1'b0, den_reg[DIV_W-1:1]};
                q_reg   <= q_fin;
                if (div_last)
                begin
                    radius_reg <= q_fin[Q_W-1] ? RADIUS_MAX : q_fin[RADIUS_W-1:0];
                    status_reg <= FIT_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_circle_radius_fit.sv -----
// Point item below the point limit: accepted, then 20 CORDIC iterations and 8 steps on the
// shared 36x36 multiplier for the running sums, before the next item is taken.
// Last item: adds the fit, 27 products on a bit-serial 400 bit shift-add unit,
// then 200 root steps and 21 divide steps before the result. One item at a time.
// rst_n is asynchronous, active low: sums and count clear, min_points goes to 3.
`default_nettype none

module lidar_circle_radius_fit
    import lcrf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // range_mm[15:0], angle_code[31:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // radius_q4[19:0], zero fill
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    top_state_t state_reg, state_next;

    logic [RANGE_W-1:0]         range_reg;
    logic                       last_reg;
    logic [1:0]                 quad_reg;
    logic signed [CORDIC_W-1:0] z_reg, cx_reg, sy_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [XY_W-1:0]     x_reg, y_reg;
    logic [RR_W-1:0]            rr_reg;
    lcrf_sums_t                 sums_reg;
    logic [CNT_W-1:0]           min_points_reg;
    logic                       m_tvalid_reg;
    logic [RADIUS_W-1:0]        radius_out_reg;
    logic [STATUS_W-1:0]        status_out_reg;

    logic                       accept, full, out_load, fit_done, cordic_last, accum_last;
    logic signed [CORDIC_W-1:0] dx, dy, atan_v, cos_v, sin_v;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   rnd;
    lcrf_fit_t                  fit;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign accept      = s_tvalid && s_tready;
    assign full        = (sums_reg.count == CNT_W'(MAX_POINTS));
    assign cordic_last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign accum_last  = (step_reg == STEP_W'(7));
    assign out_load    = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24-RADIUS_W){1'b0}}, radius_out_reg};
    assign m_tuser  = status_out_reg;

    lcrf_solver u_solver (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_START),
        .sums  (sums_reg),
        .done  (fit_done),
        .fit   (fit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        state_next = ST_CORDIC;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cordic_last)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (accum_last)
                begin
                    state_next = last_reg ? ST_START : ST_IDLE;
                end
            end
            ST_START: state_next = ST_SOLVE;
            ST_SOLVE:
            begin
                if (fit_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // CORDIC micro-rotation
    assign dx     = sy_reg >>> iter_reg;
    assign dy     = cx_reg >>> iter_reg;
    assign atan_v = CORDIC_W'({2'b00, lcrf_atan(iter_reg)});

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = cx_reg;
                sin_v = sy_reg;
            end
            2'd1:
            begin
                cos_v = -sy_reg;
                sin_v = cx_reg;
            end
            2'd2:
            begin
                cos_v = -cx_reg;
                sin_v = -sy_reg;
            end
            default:
            begin
                cos_v = sy_reg;
                sin_v = -cx_reg;
            end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = MUL_W'({1'b0, range_reg});
                mul_b = MUL_W'(cos_v);
            end
            3'd1:
            begin
                mul_a = MUL_W'({1'b0, range_reg});
                mul_b = MUL_W'(sin_v);
            end
            3'd2:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            3'd3:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            3'd4:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(y_reg);
            end
            3'd5:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'({1'b0, rr_reg});
            end
            3'd6:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'({1'b0, rr_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up of range * trig / 2^30
    assign rnd = prod_reg + PROD_W'(64'sd536870912);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg <= s_tdata[RANGE_W-1:0];
            last_reg  <= s_tlast;
            quad_reg  <= s_tdata[31:30];
            z_reg     <= CORDIC_W'({s_tdata[29:16], 16'd0});
            cx_reg    <= CORDIC_GAIN;
            sy_reg    <= '0;
        end
        else if (state_reg == ST_CORDIC)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                cx_reg <= cx_reg - dx;
                sy_reg <= sy_reg + dy;
                z_reg  <= z_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                sy_reg <= sy_reg - dy;
                z_reg  <= z_reg + atan_v;
            end
        end
        if (state_reg == ST_ACCUM)
        begin
            prod_reg <= mul_a * mul_b;
            case (step_reg)
                3'd1:    x_reg  <= rnd[47:30];
                3'd2:    y_reg  <= rnd[47:30];
                3'd3:    rr_reg <= prod_reg[RR_W-1:0];
                3'd4:    rr_reg <= rr_reg + prod_reg[RR_W-1:0];
                default: ;
            endcase
        end
        if (out_load)
        begin
            radius_out_reg <= fit.radius;
            status_out_reg <= (sums_reg.count < min_points_reg) ? FIT_TOO_FEW : fit.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg       <= '0;
            step_reg       <= '0;
            sums_reg       <= '0;
            min_points_reg <= CNT_W'(3);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_points_reg <= cfg_data;
            end
            if (accept)
            begin
                iter_reg <= '0;
                step_reg <= '0;
            end
            else if (state_reg == ST_CORDIC)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            else if (state_reg == ST_ACCUM)
            begin
                step_reg <= step_reg + STEP_W'(1);
                case (step_reg)
                    3'd3: sums_reg.sum_xx <= sums_reg.sum_xx + prod_reg[SXX_W-1:0];
                    3'd4: sums_reg.sum_yy <= sums_reg.sum_yy + prod_reg[SXX_W-1:0];
                    3'd5:
                    begin
                        sums_reg.sum_xy  <= sums_reg.sum_xy + prod_reg[SXY_W-1:0];
                        sums_reg.sum_rsq <= sums_reg.sum_rsq + SR_W'(rr_reg);
                        sums_reg.sum_x   <= sums_reg.sum_x + SX_W'(x_reg);
                        sums_reg.sum_y   <= sums_reg.sum_y + SX_W'(y_reg);
                    end
                    3'd6: sums_reg.sum_x_rsq <= sums_reg.sum_x_rsq + prod_reg[SXR_W-1:0];
                    3'd7:
                    begin
                        sums_reg.sum_y_rsq <= sums_reg.sum_y_rsq + prod_reg[SXR_W-1:0];
                        sums_reg.count     <= sums_reg.count + CNT_W'(1);
                    end
                    default: ;
                endcase
            end
            if (out_load)
            begin
                sums_reg     <= '0;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sums_reg.count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond limit");

    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (sums_reg.count == '0))
        else $error("sums not cleared with result");

    // a non-last item dropped at the point limit leaves the input ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (!full || s_tlast)) |=> !s_tready)
        else $error("ready right after an accepted item");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |=> !fit_done)
        else $error("fit done without solving");
`endif

endmodule

`default_nettype wire

// ----- verif/lidar_circle_radius_fit_tb.sv -----
`default_nettype none

module lidar_circle_radius_fit_tb;
    import lcrf_pkg::*;

    typedef logic signed [511:0] wide_t;

    typedef struct {
        logic [15:0] range_mm;
        logic [15:0] angle;
        logic        last;
        logic        typed;
        logic [19:0] radius;
        logic [1:0]  status;
    } row_t;

    typedef struct {
        logic [19:0] radius;
        logic [1:0]  status;
    } fit_exp_t;

    localparam longint CYCLE_LIMIT = 64'd200_000_000;
    localparam int     ITEMS       = 1950;
    localparam int     SETTLE      = 64;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    lidar_circle_radius_fit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    longint      acc_xx, acc_xy, acc_x, acc_yy, acc_y, acc_xr, acc_yr, acc_r;
    int unsigned acc_cnt;
    int unsigned min_pts;

    fit_exp_t fit_q[$];
    int       errors;
    int       items_sent;
    int       fits_seen [4];
    longint   cycles;
    bit       quiet;
    bit       hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("cycle limit hit with %0d fits pending", fit_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic void polar_to_xy(input logic [15:0] rng, input logic [15:0] ang,
                                        output longint x, output longint y);
        longint atan_q30 [20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                  21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                  333772, 166886, 83443, 41722, 20861, 10430, 5215,
                                  2608, 1304};
        longint z, vc, vs, dx, dy, c, s, r;
        logic [31:0] z32;
        z32 = {ang, 16'h0};
        z   = longint'(z32[29:0]);
        vc  = 652032874;
        vs  = 0;
        for (int i = 0; i < 20; i++)
        begin
            dx = vs >>> i;
            dy = vc >>> i;
            if (z >= 0)
            begin
                vc -= dx; vs += dy; z -= atan_q30[i];
            end
            else
            begin
                vc += dx; vs -= dy; z += atan_q30[i];
            end
        end
        case (z32[31:30])
            2'd0:    begin c = vc;  s = vs;  end
            2'd1:    begin c = -vs; s = vc;  end
            2'd2:    begin c = -vc; s = -vs; end
            default: begin c = vs;  s = -vc; end
        endcase
        r = longint'(rng);
        x = (r * c + (64'sd1 <<< 29)) >>> 30;
        y = (r * s + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic wide_t det3(input wide_t a0, a1, a2, a3, a4, a5, a6, a7, a8);
        return a0 * (a4 * a8 - a5 * a7) - a1 * (a3 * a8 - a5 * a6)
             + a2 * (a3 * a7 - a4 * a6);
    endfunction

    function automatic wide_t wide_isqrt(input wide_t v);
        wide_t res, t;
        res = '0;
        for (int b = 223; b >= 0; b--)
        begin
            t = res | (wide_t'(1) <<< b);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    function automatic void clear_acc();
        acc_xx = 0; acc_xy = 0; acc_x = 0; acc_yy = 0; acc_y = 0;
        acc_xr = 0; acc_yr = 0; acc_r = 0; acc_cnt = 0;
    endfunction

    // fold one point into the sums; on a last item solve and return the fit
    function automatic bit fit_point(input logic [15:0] rng, input logic [15:0] ang,
                                     input logic last, output fit_exp_t res);
        longint x, y, rr;
        wide_t sxx, sxy, sx, syy, sy, sxr, syr, sr, cnt, d, da, db, dc, n, mag, q;
        res.radius = '0;
        res.status = FIT_OK;
        if (acc_cnt < MAX_POINTS)
        begin
            polar_to_xy(rng, ang, x, y);
            rr = x * x + y * y;
            acc_xx += x * x; acc_xy += x * y; acc_x += x;
            acc_yy += y * y; acc_y += y;
            acc_xr += x * rr; acc_yr += y * rr; acc_r += rr;
            acc_cnt++;
        end
        if (!last)
            return 1'b0;
        sxx = acc_xx; sxy = acc_xy; sx = acc_x; syy = acc_yy; sy = acc_y;
        sxr = acc_xr; syr = acc_yr; sr = acc_r; cnt = wide_t'(acc_cnt);
        d  = det3(sxx, sxy, sx,  sxy, syy, sy,  sx,  sy,  cnt);
        da = det3(sxr, sxy, sx,  syr, syy, sy,  sr,  sy,  cnt);
        db = det3(sxx, sxr, sx,  sxy, syr, sy,  sx,  sr,  cnt);
        dc = det3(sxx, sxy, sxr, sxy, syy, syr, sx,  sy,  sr);
        n  = 4 * dc * d + da * da + db * db;
        if (d == 0)
            res.status = FIT_SINGULAR;
        else if (n < 0)
            res.status = FIT_NEG_RAD;
        else
        begin
            mag = (d < 0) ? -d : d;
            q   = (wide_isqrt(n <<< 8) + mag) / (2 * mag);
            res.radius = (q >= (wide_t'(1) <<< 20)) ? RADIUS_MAX : q[19:0];
        end
        if (acc_cnt < min_pts)
            res.status = FIT_TOO_FEW;
        clear_acc();
        return 1'b1;
    endfunction

    task automatic send_point(input row_t r);
        fit_exp_t e;
        if (!quiet && ($urandom_range(0, 7) == 0))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.angle, r.range_mm};
        s_tlast  <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (fit_point(r.range_mm, r.angle, r.last, e))
        begin
            if (r.typed)
            begin
                e.radius = r.radius;
                e.status = r.status;
            end
            fit_q.push_back(e);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (fit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_min_points(input logic [10:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_pts = v;
        @(posedge clk);
    endtask

    function automatic row_t pt(input logic [15:0] rng, input logic [15:0] ang,
                                input logic last);
        row_t r;
        r.range_mm = rng; r.angle = ang; r.last = last;
        r.typed = 1'b0; r.radius = '0; r.status = FIT_OK;
        return r;
    endfunction

    function automatic row_t pt_exp(input logic [15:0] rng, input logic [15:0] ang,
                                    input logic [19:0] rad, input logic [1:0] st);
        row_t r;
        r = pt(rng, ang, 1'b1);
        r.typed = 1'b1; r.radius = rad; r.status = st;
        return r;
    endfunction

    // receiver check; m_tready itself comes from the stall process below
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (fit_q.size() == 0)
            begin
                $error("fit result with nothing expected: radius %0d status %0d",
                       m_tdata[19:0], m_tuser);
                errors++;
            end
            else
            begin
                fit_exp_t e;
                e = fit_q.pop_front();
                if (m_tdata[19:0] !== e.radius)
                begin
                    $error("radius_q4 expected %0d actual %0d", e.radius, m_tdata[19:0]);
                    errors++;
                end
                if (m_tuser !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tuser);
                    errors++;
                end
                fits_seen[e.status]++;
            end
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (4000) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && ($urandom_range(0, 5) == 0))
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        row_t directed [$];
        int   len, kind, rad, a0, stp, nset;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        errors    = 0;
        items_sent = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        foreach (fits_seen[i]) fits_seen[i] = 0;
        min_pts   = 3;
        clear_acc();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single zero-range point straight after reset: count 1 is below the default minimum
        directed.push_back(pt_exp(16'd0, 16'd0, 20'd0, FIT_TOO_FEW));
        // collinear on the x axis: y sums vanish, system singular
        directed.push_back(pt(16'd100, 16'd0, 1'b0));
        directed.push_back(pt(16'd200, 16'd0, 1'b0));
        directed.push_back(pt_exp(16'd300, 16'd0, 20'd0, FIT_SINGULAR));
        // circle about the origin, quadrant boundaries and the top angle code
        directed.push_back(pt(16'd1000, 16'd0, 1'b0));
        directed.push_back(pt(16'd1000, 16'd16384, 1'b0));
        directed.push_back(pt(16'd1000, 16'd32768, 1'b0));
        directed.push_back(pt(16'd1000, 16'd49152, 1'b0));
        directed.push_back(pt(16'd1000, 16'd65535, 1'b1));
        // full range, near-collinear: radius close to saturation
        directed.push_back(pt(16'd65535, 16'd0, 1'b0));
        directed.push_back(pt(16'd65535, 16'd1, 1'b0));
        directed.push_back(pt(16'd65535, 16'd2, 1'b1));
        // two points only: fewer than the minimum
        directed.push_back(pt(16'd500, 16'd1234, 1'b0));
        directed.push_back(pt(16'd700, 16'd40000, 1'b1));
        // all zero ranges
        directed.push_back(pt(16'd0, 16'hFFFF, 1'b0));
        directed.push_back(pt(16'd0, 16'h5555, 1'b0));
        directed.push_back(pt(16'd0, 16'hAAAA, 1'b1));
        foreach (directed[i])
            send_point(directed[i]);

        // minimum 0 never flags: a single zero-range point reads singular
        set_min_points(11'd0);
        send_point(pt_exp(16'd0, 16'd0, 20'd0, FIT_SINGULAR));
        set_min_points(11'h7FF);
        send_point(pt(16'd3000, 16'd100, 1'b0));
        send_point(pt(16'd3000, 16'd9000, 1'b0));
        send_point(pt(16'd3000, 16'd30000, 1'b1));
        set_min_points(11'd3);

        // overfull set: count saturates at the point limit, last not folded in
        set_min_points(11'd1024);
        len = MAX_POINTS + 6;
        for (int i = 0; i < len; i++)
            send_point(pt(16'($urandom_range(2000, 2100)), 16'($urandom),
                          (i == len - 1)));
        hold_req = 1'b1;

        nset = 0;
        while (items_sent < ITEMS)
        begin
            if (items_sent > ITEMS - 150)
                quiet = 1'b1;
            if ((nset % 12) == 11)
            begin
                case ($urandom_range(0, 3))
                    0:       set_min_points(11'd3);
                    1:       set_min_points(11'd0);
                    2:       set_min_points(11'h7FF);
                    default: set_min_points(11'($urandom_range(1, 64)));
                endcase
            end
            nset++;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_point(pt(16'($urandom), 16'($urandom), (i == len - 1)));
            end
            else if (kind == 9)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_point(pt(16'($urandom), 16'($urandom), (i == len - 1)));
            end
            else
            begin
                // noisy arc of returns about a common radius
                len = $urandom_range(3, 60);
                rad = $urandom_range(50, 65000);
                a0  = $urandom;
                stp = $urandom_range(1, 2000);
                for (int i = 0; i < len; i++)
                begin
                    int rr;
                    rr = rad + $urandom_range(0, 20) - 10;
                    if (rr < 0) rr = 0;
                    if (rr > 65535) rr = 65535;
                    send_point(pt(16'(rr), 16'(a0 + i * stp), (i == len - 1)));
                end
            end
        end

        drain();
        $display("sent %0d points; fits ok %0d, too few %0d, singular %0d, neg radicand %0d",
                 items_sent, fits_seen[0], fits_seen[1], fits_seen[2], fits_seen[3]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
